>>> src/bed_pkg.sv
// Shared types, widths and codes for the bounded edit distance block.
`default_nettype none

package bed_pkg;

  // Default longest word, in characters.
  localparam int MAX_WORD_LEN_DEF = 32;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int DIST_W = 6;
  localparam int MIN_W  = DIST_W + 1;  // row minimum may reach edit_limit+1 = 64

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] LIMIT_RST  = DIST_W'(32);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Data handed from one column cell to the next, once per row.
  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  sym;   // character of the first word for this row
    logic [DIST_W-1:0] left;  // D[i][j-1]
    logic [DIST_W-1:0] diag;  // D[i-1][j-1]
    logic [MIN_W-1:0]  rmin;  // running row minimum
  } link_t;

endpackage

`default_nettype wire

>>> src/bounded_edit_distance.sv
// Top level: word capture, row feeder, column cell chain and result control.
//
//  channel | dir | tdata fields (low bit up)              | notes
//  in_     | in  | operation[1:0], symbol[9:2], pad[15:10] | append or compute
//  out_    | out | distance[5:0], over_limit[6], pad[7]    | one per compute
//  cfg_    | in  | edit_limit[5:0]                        | write only
//
// Appends are taken while the controller is idle. After a compute item is
// taken the controller passes the start, run and emit states: one row of the
// table enters the cell chain per cycle and each row crosses MAX_WORD_LEN
// registered cells; early results from the length test or an empty first
// word go from the start state straight to the emit state.
// Reset is synchronous, active low; no clearing pass is needed.
// in_tready is low while a compute runs; a finished result waits in the
// output register, and appends are taken meanwhile.
`default_nettype none

module bounded_edit_distance
  import bed_pkg::*;
#(
  parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // operation[1:0], symbol[9:2]
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [7:0]        out_tdata,  // distance[5:0], over_limit[6]
  input  wire logic              cfg_wr_en,
  input  wire logic [DIST_W-1:0] cfg_wr_data
);

  localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  state_t state_r, state_nxt;

  logic [DIST_W-1:0] limit_r;
  logic [LEN_W-1:0]  xs_r, xs_nxt, ys_r, ys_nxt;
  logic [LEN_W-1:0]  issue_r, issue_nxt, arr_r, arr_nxt;
  logic              feed_valid_r;
  logic [LEN_W-1:0]  feed_row_r;
  logic              hit_r, hit_nxt;
  logic [DIST_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_over_r;

  logic [OP_W-1:0]   in_op;
  logic [SYM_W-1:0]  in_sym;
  logic              in_fire, app_first, app_second, cmp_fire;
  logic [SYM_W-1:0]  rd_data;
  logic              cells_init, rd_en, emit_fire, out_free;
  logic [LEN_W-1:0]  diff;
  logic              arrive, arr_last, row_over;
  logic [DIST_W-1:0] row_min_sat;

  link_t             links [MAX_WORD_LEN+1];

  assign in_op      = in_tdata[OP_W-1:0];
  assign in_sym     = in_tdata[OP_W+SYM_W-1:OP_W];
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign app_first  = in_fire && (in_op == OP_APPEND_FIRST)  && (xs_r < LEN_W'(MAX_WORD_LEN));
  assign app_second = in_fire && (in_op == OP_APPEND_SECOND) && (ys_r < LEN_W'(MAX_WORD_LEN));
  assign cmp_fire   = in_fire && (in_op == OP_COMPUTE);
  assign out_free   = !out_valid_r || out_tready;
  assign diff       = (xs_r > ys_r) ? (xs_r - ys_r) : (ys_r - xs_r);

  // Edit limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // First word storage
  bed_word_mem #(
    .DEPTH (MAX_WORD_LEN),
    .AW    (IDX_W)
  ) u_first_word (
    .clk     (clk),
    .wr_en   (app_first),
    .wr_addr (xs_r[IDX_W-1:0]),
    .wr_data (in_sym),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Row feeder into column 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_valid_r <= 1'b0;
    end else begin
      feed_valid_r <= rd_en;
    end
    feed_row_r <= issue_r + LEN_W'(1);
  end

  always_comb begin
    links[0].valid = feed_valid_r;
    links[0].sym   = rd_data;
    links[0].left  = DIST_W'(feed_row_r);
    links[0].diag  = DIST_W'(feed_row_r - LEN_W'(1));
    links[0].rmin  = {1'b0, limit_r} + MIN_W'(1);
  end

  // Column cell chain, cell k holds table column k
  for (genvar k = 1; k <= MAX_WORD_LEN; k++) begin : g_cell
    bed_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init     (cells_init),
      .init_val (DIST_W'(k)),
      .active   (ys_r >= LEN_W'(k)),
      .sym_we   (app_second && (ys_r == LEN_W'(k - 1))),
      .sym_in   (in_sym),
      .link_in  (links[k-1]),
      .link_out (links[k])
    );
  end

  // Row results leaving the chain
  assign arrive      = links[MAX_WORD_LEN].valid;
  assign arr_last    = arrive && ((arr_r + LEN_W'(1)) == xs_r);
  assign row_over    = links[MAX_WORD_LEN].rmin > {1'b0, limit_r};
  assign row_min_sat = links[MAX_WORD_LEN].rmin[MIN_W-1] ? DIST_MAX :
                       links[MAX_WORD_LEN].rmin[DIST_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (cmp_fire) state_nxt = ST_START;
      ST_START: begin
        if ((DIST_W'(diff) > limit_r) || (xs_r == '0)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN:   if (arr_last) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    cells_init = 1'b0;
    rd_en      = 1'b0;
    emit_fire  = 1'b0;
    case (state_r)
      ST_START: cells_init = 1'b1;
      ST_RUN:   rd_en      = (issue_r < xs_r);
      ST_EMIT:  emit_fire  = out_free;
      default:  ;
    endcase
  end

  // Lengths, counters and result tracking
  always_comb begin
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    issue_nxt = issue_r;
    arr_nxt   = arr_r;
    hit_nxt   = hit_r;
    res_nxt   = res_r;
    if (app_first)  xs_nxt = xs_r + LEN_W'(1);
    if (app_second) ys_nxt = ys_r + LEN_W'(1);
    if (cells_init) begin
      issue_nxt = '0;
      arr_nxt   = '0;
      if (DIST_W'(diff) > limit_r) begin
        hit_nxt = 1'b1;
        res_nxt = DIST_W'(diff);
      end else begin
        hit_nxt = 1'b0;
        res_nxt = DIST_W'(ys_r);
      end
    end
    if (rd_en) issue_nxt = issue_r + LEN_W'(1);
    if (arrive) begin
      arr_nxt = arr_r + LEN_W'(1);
      if (!hit_r) begin
        if (row_over) begin
          hit_nxt = 1'b1;
          res_nxt = row_min_sat;
        end else if (arr_last) begin
          res_nxt = links[MAX_WORD_LEN].left;
        end
      end
    end
    if (emit_fire) begin
      xs_nxt = '0;
      ys_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      xs_r    <= '0;
      ys_r    <= '0;
      issue_r <= '0;
      arr_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      xs_r    <= xs_nxt;
      ys_r    <= ys_nxt;
      issue_r <= issue_nxt;
      arr_r   <= arr_nxt;
      hit_r   <= hit_nxt;
    end
    res_r <= res_nxt;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit_fire) begin
      out_dist_r <= res_r;
      out_over_r <= hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_over_r, out_dist_r};

  // An exact result never exceeds the longest word
  a_exact_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_over_r) |-> (out_dist_r <= DIST_W'(MAX_WORD_LEN)))
    else $error("exact distance above word length");

  // A flagged result lies above the limit, or is saturated
  a_over_above_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_over_r) |-> ((out_dist_r > limit_r) || (out_dist_r == DIST_MAX)))
    else $error("flagged distance not above edit limit");

  // Rows never leave the chain before they were issued
  a_arrivals_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (arr_r <= issue_r))
    else $error("more rows arrived than issued");

  // Word lengths stay within storage
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (xs_r <= LEN_W'(MAX_WORD_LEN)) && (ys_r <= LEN_W'(MAX_WORD_LEN)))
    else $error("word length beyond storage");

endmodule

`default_nettype wire

>>> src/bed_word_mem.sv
// Single-port-write, registered-read storage for the first word.
`default_nettype none

module bed_word_mem
  import bed_pkg::*;
#(
  parameter int DEPTH = MAX_WORD_LEN_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [SYM_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [SYM_W-1:0] rd_data
);

  logic [SYM_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/bed_cell.sv
// One column cell of the systolic edit distance array.
`default_nettype none

module bed_cell
  import bed_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              init,      // load row-0 value
  input  wire logic [DIST_W-1:0] init_val,  // column index j
  input  wire logic              active,    // column lies within the second word
  input  wire logic              sym_we,    // capture this column's character
  input  wire logic [SYM_W-1:0]  sym_in,
  input  wire link_t             link_in,
  output link_t                  link_out
);

  logic [SYM_W-1:0]  sym_r;
  logic [DIST_W-1:0] col_r, col_nxt;
  link_t             link_r, link_nxt;

  logic              cost;
  logic [MIN_W-1:0]  c_diag, c_up, c_left, c_min;
  logic [DIST_W-1:0] cell_val;

  // Three-way recurrence
  always_comb begin
    cost   = (link_in.sym != sym_r);
    c_diag = {1'b0, link_in.diag} + MIN_W'(cost);
    c_up   = {1'b0, col_r} + MIN_W'(1);
    c_left = {1'b0, link_in.left} + MIN_W'(1);
    c_min  = (c_up < c_left) ? c_up : c_left;
    c_min  = (c_diag < c_min) ? c_diag : c_min;
    // table values never exceed the longer word length, so this fits
    cell_val = c_min[DIST_W-1:0];
  end

  // Update or pass through
  always_comb begin
    col_nxt  = col_r;
    link_nxt = link_in;
    if (init) begin
      col_nxt = init_val;
    end else if (active && link_in.valid) begin
      col_nxt       = cell_val;
      link_nxt.left = cell_val;
      link_nxt.diag = col_r;
      link_nxt.rmin = ({1'b0, cell_val} < link_in.rmin) ? {1'b0, cell_val} : link_in.rmin;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_r <= sym_in;
    end
    col_r <= col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for bounded_edit_distance: word pairs against an in-bench predictor.
module tb_top
  import bed_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = MAX_WORD_LEN_DEF;
  localparam int STAGE_LEN = MAX_LEN + 8;            // room for appends past a full word
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = MAX_LEN + 48;       // longer than the slowest compute
  localparam int LONG_HOLD = 300;
  localparam int TARGET_ITEMS = 650;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              over_limit;
  } dist_result_t;

  // DUT connections, known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;     // operation[1:0], symbol[9:2]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // distance[5:0], over_limit[6]
  logic              cfg_wr_en = 1'b0;
  logic [DIST_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic [SYM_W-1:0]  first_chars [MAX_LEN];
  logic [SYM_W-1:0]  second_chars [MAX_LEN];
  int                first_count = 0;
  int                second_count = 0;
  logic [DIST_W-1:0] limit_reg = LIMIT_RST;
  dist_result_t      dist_expected [$];

  // staging for the next word pair
  logic [SYM_W-1:0]  word_a [STAGE_LEN];
  logic [SYM_W-1:0]  word_b [STAGE_LEN];
  int                len_a, len_b;

  // run control and bookkeeping
  bit                idle_on = 1'b1;
  int                hold_request = 0;
  int                items_sent = 0;
  int                computes = 0;
  int                over_results = 0;
  int                limit_writes = 0;
  int                mismatches = 0;

  bounded_edit_distance uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // saturate to the distance field
  function automatic dist_result_t pack_result(int d, bit flag);
    dist_result_t r;
    r.distance = (d > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(d);
    r.over_limit = flag;
    return r;
  endfunction

  // row-by-row edit distance with the two early exits
  function automatic dist_result_t predict_distance();
    int bound, diff, i, j, row_min, diag, up, cand;
    int row [MAX_LEN+1];
    bound = int'(limit_reg);
    diff = (first_count > second_count) ? first_count - second_count
                                        : second_count - first_count;
    if (diff > bound) return pack_result(diff, 1'b1);
    for (j = 0; j <= second_count; j++) row[j] = j;
    for (i = 1; i <= first_count; i++) begin
      row_min = bound + 1;
      diag = row[0];
      row[0] = i;
      for (j = 1; j <= second_count; j++) begin
        up = row[j];
        cand = diag + ((first_chars[i-1] == second_chars[j-1]) ? 0 : 1);
        if (up + 1 < cand) cand = up + 1;
        if (row[j-1] + 1 < cand) cand = row[j-1] + 1;
        diag = up;
        row[j] = cand;
        if (cand < row_min) row_min = cand;
      end
      if (row_min > bound) return pack_result(row_min, 1'b1);
    end
    return pack_result(row[second_count], 1'b0);
  endfunction

  // apply one accepted item to the predictor
  task automatic track_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    dist_result_t r;
    case (op)
      OP_APPEND_FIRST: begin
        if (first_count < MAX_LEN) begin
          first_chars[first_count] = sym;
          first_count++;
        end
      end
      OP_APPEND_SECOND: begin
        if (second_count < MAX_LEN) begin
          second_chars[second_count] = sym;
          second_count++;
        end
      end
      OP_COMPUTE: begin
        r = predict_distance();
        dist_expected = {dist_expected, r};
        computes++;
        if (r.over_limit) over_results++;
        first_count = 0;
        second_count = 0;
      end
      default: ;
    endcase
  endtask

  // offer one item after a random gap, return once it is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, sym, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_item(op, sym);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop offering, wait for all results, then let the block settle
  task automatic wait_results(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (dist_expected.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] value);
    wait_results(SETTLE_CYCLES);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
    limit_writes++;
  endtask

  // mostly short words, now and then long enough to fill up
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 20);
    return $urandom_range(21, STAGE_LEN - 4);
  endfunction

  // random pair; small alphabet for matches, second word often a near copy
  task automatic make_pair();
    logic [SYM_W-1:0] alpha [4];
    bit wide;
    int k;
    for (k = 0; k < 4; k++) alpha[k] = SYM_W'($urandom_range(0, 255));
    wide = ($urandom_range(0, 4) == 0);
    len_a = pick_len();
    for (k = 0; k < len_a; k++)
      word_a[k] = wide ? SYM_W'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)];
    if ($urandom_range(0, 1) == 1) begin
      len_b = len_a + $urandom_range(0, 4) - 2;
      if (len_b < 0) len_b = 0;
      for (k = 0; k < len_b; k++)
        word_b[k] = (k < len_a && $urandom_range(0, 3) != 0) ? word_a[k]
                                                             : alpha[$urandom_range(0, 3)];
    end else begin
      len_b = pick_len();
      for (k = 0; k < len_b; k++)
        word_b[k] = wide ? SYM_W'($urandom_range(0, 255)) : alpha[$urandom_range(0, 3)];
    end
  endtask

  // send the staged pair and a compute; appends in order or interleaved
  task automatic send_pair(input bit interleave, input bit noise);
    int ia, ib;
    bit take_first;
    ia = 0;
    ib = 0;
    while (ia < len_a || ib < len_b) begin
      if (noise && $urandom_range(0, 19) == 0)
        send_item(OP_UNUSED, SYM_W'($urandom_range(0, 255)));
      take_first = (ia < len_a) &&
                   (ib >= len_b || !interleave || $urandom_range(0, 1) == 1);
      if (take_first) begin
        send_item(OP_APPEND_FIRST, word_a[ia]);
        ia++;
      end else begin
        send_item(OP_APPEND_SECOND, word_b[ib]);
        ib++;
      end
    end
    send_item(OP_COMPUTE, SYM_W'($urandom_range(0, 255)));
  endtask

  // field extremes and the named corner cases
  task automatic test_directed();
    // both words empty
    send_item(OP_COMPUTE, 8'h00);
    // unused operation does nothing
    send_item(OP_UNUSED, 8'hFF);
    // empty first word
    send_item(OP_APPEND_SECOND, 8'h00);
    send_item(OP_APPEND_SECOND, 8'hFF);
    send_item(OP_COMPUTE, 8'hFF);
    // empty second word, bound from the row minimum
    send_item(OP_APPEND_FIRST, 8'h41);
    send_item(OP_COMPUTE, 8'h00);
    // match at the top symbol with an ignored item in between
    send_item(OP_APPEND_FIRST, 8'hFF);
    send_item(OP_UNUSED, 8'h55);
    send_item(OP_APPEND_SECOND, 8'hFF);
    send_item(OP_COMPUTE, 8'hAA);
    // single substitution
    send_item(OP_APPEND_FIRST, 8'h00);
    send_item(OP_APPEND_SECOND, 8'hFF);
    send_item(OP_COMPUTE, 8'h00);
    // zero limit: row test and length test
    write_limit(6'd0);
    send_item(OP_APPEND_FIRST, 8'h00);
    send_item(OP_APPEND_SECOND, 8'h01);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_APPEND_FIRST, 8'h7F);
    send_item(OP_APPEND_FIRST, 8'h80);
    send_item(OP_COMPUTE, 8'h00);
    // widest limit with empty second word saturates the distance
    write_limit(DIST_MAX);
    send_item(OP_APPEND_FIRST, 8'h12);
    send_item(OP_COMPUTE, 8'h00);
  endtask

  // appends past a full word are dropped
  task automatic test_word_full();
    int k;
    write_limit(LIMIT_RST);
    len_a = STAGE_LEN;
    len_b = STAGE_LEN - 3;
    for (k = 0; k < STAGE_LEN; k++) begin
      word_a[k] = SYM_W'($urandom_range(0, 3));
      word_b[k] = (k % 9 == 4) ? ~word_a[k] : word_a[k];
    end
    send_pair(1'b0, 1'b0);
    // full first word against empty second
    len_b = 0;
    len_a = MAX_LEN + 2;
    send_pair(1'b0, 1'b0);
    // empty first word against full second
    len_a = 0;
    len_b = STAGE_LEN;
    send_pair(1'b0, 1'b0);
  endtask

  // random pairs, lone computes and unused items until the budget is spent
  task automatic test_random(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(OP_COMPUTE, SYM_W'($urandom_range(0, 255)));
      end else begin
        make_pair();
        send_pair($urandom_range(0, 2) == 0, 1'b1);
      end
    end
  endtask

  // both sides without idle cycles
  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random(60);
    wait_results(0);
    idle_on = 1'b1;
  endtask

  // receiver holds off while pairs keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    hold_request = LONG_HOLD;
    for (n = 0; n < 4; n++) begin
      make_pair();
      send_pair(1'b1, 1'b0);
    end
  endtask

  // sender waits for every result before each new pair
  task automatic test_sender_pause();
    int n;
    for (n = 0; n < 3; n++) begin
      make_pair();
      send_pair(1'b0, 1'b1);
      wait_results(0);
    end
  endtask

  // result checker and receiver idling
  initial begin
    int stall_left;
    dist_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (dist_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: distance %0d over_limit %0d",
                     out_tdata[5:0], out_tdata[6]);
        end else begin
          want = dist_expected.pop_front();
          if (out_tdata[5:0] !== want.distance || out_tdata[6] !== want.over_limit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected distance %0d over_limit %0d, got %0d %0d",
                       want.distance, want.over_limit, out_tdata[5:0], out_tdata[6]);
          end
        end
        stall_left = idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

  // test sequence
  initial begin
    int errors;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_word_full();
    write_limit(LIMIT_RST);
    test_random(120);
    write_limit(6'd0);
    test_random(60);
    write_limit(DIST_MAX);
    test_random(80);
    write_limit(6'd3);
    test_random(80);
    test_full_rate();
    write_limit(DIST_W'($urandom_range(1, 12)));
    test_backpressure();
    test_sender_pause();
    write_limit(DIST_W'($urandom_range(0, 63)));
    if (items_sent < TARGET_ITEMS) test_random(TARGET_ITEMS - items_sent);

    wait_results(SETTLE_CYCLES);
    errors = mismatches + dist_expected.size();
    $display("covered %0d items, %0d distance results (%0d over the limit), %0d limit writes",
             items_sent, computes, over_results, limit_writes);
    $display("mismatching results: %0d", mismatches);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
